>>> design/tdpt_pkg.sv
// tdpt_pkg: shared constants for the trial division prime test core
// used by the core, its divider and its port checker; no dependencies

package tdpt_pkg;

  localparam int unsigned VALUE_WIDTH     = 32;
  localparam int unsigned CANDIDATE_WIDTH = 32;
  localparam int unsigned FIRST_DIVISOR   = 3;
  localparam int unsigned DIVISOR_STEP    = 2;
  localparam int unsigned SMALLEST_PRIME  = 2;

endpackage

>>> design/tdpt_divider.sv
// tdpt_divider: bit-serial restoring divider, one quotient bit per cycle
// depends on tdpt_pkg for the default width

module tdpt_divider #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [VALUE_WIDTH-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q;
  logic                   done_q;
  logic [CntW-1:0]        cnt_q;
  logic [VALUE_WIDTH-1:0] quo_q;
  logic [VALUE_WIDTH-1:0] quo_d;
  logic [VALUE_WIDTH-1:0] rem_q;
  logic [VALUE_WIDTH-1:0] rem_d;
  logic [VALUE_WIDTH-1:0] div_q;
  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH:0]   diff;
  logic                   take;

  // shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    rem_sh = {rem_q, quo_q[VALUE_WIDTH-1]};
    diff   = rem_sh - {1'b0, div_q};
    take   = ~diff[VALUE_WIDTH];
    rem_d  = take ? diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
    quo_d  = {quo_q[VALUE_WIDTH-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(VALUE_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> design/trial_division_prime_test_core.sv
// trial_division_prime_test_core: primality test of one signed word per item
// depends on tdpt_pkg and tdpt_divider
//
// Each accepted candidate gives one flag word. Negative values, zero, one, two
// and even values above two are settled on acceptance; the flag is registered
// at once if the output register is free, else held in S_HOLD until it is.
// Odd values from three up are tried against the divisors 3, 5, 7 and so on;
// each trial is one pass of the bit-serial divider, which yields both the
// quotient (trials stop once it drops below the divisor or the remainder is
// zero) and the remainder. An odd candidate n thus takes about sqrt(n) / 2
// trials. One candidate is worked on at a time; the next one is taken as soon
// as the finished flag sits in the output register.

module trial_division_prime_test_core #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  logic signed [tdpt_pkg::CANDIDATE_WIDTH-1:0] candidate_i,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output logic                                        is_prime_flag_o
);

  localparam int unsigned CandW = tdpt_pkg::CANDIDATE_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_e;

  state_e                 state_q;
  logic                   out_valid_q;
  logic                   flag_q;
  logic                   pend_q;
  logic                   start_q;
  logic [VALUE_WIDTH-1:0] n_q;
  logic [VALUE_WIDTH-1:0] d_q;

  logic [VALUE_WIDTH-1:0] cand_n;
  logic                   decided;
  logic                   dec_flag;
  logic                   out_free;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [VALUE_WIDTH-1:0] div_rem;
  logic                   q_lt_d;
  logic                   rem_zero;

  if (VALUE_WIDTH <= CandW) begin : g_trunc
    assign cand_n = candidate_i[VALUE_WIDTH-1:0];
  end else begin : g_sext
    assign cand_n = {{(VALUE_WIDTH - CandW){candidate_i[CandW-1]}}, candidate_i};
  end

  // negative, zero, one, two and other even values need no trial division
  always_comb begin
    dec_flag = (cand_n == VALUE_WIDTH'(tdpt_pkg::SMALLEST_PRIME));
    decided  = cand_n[VALUE_WIDTH-1] || (cand_n[VALUE_WIDTH-1:1] == '0) ||
               dec_flag || !cand_n[0];
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign q_lt_d     = (div_quo < d_q);
  assign rem_zero   = (div_rem == '0);

  tdpt_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .dividend_i  (n_q),
    .divisor_i   (d_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      flag_q      <= 1'b0;
      pend_q      <= 1'b0;
      start_q     <= 1'b0;
      n_q         <= '0;
      d_q         <= '0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (decided) begin
              if (out_free) begin
                out_valid_q <= 1'b1;
                flag_q      <= dec_flag;
              end else begin
                pend_q  <= dec_flag;
                state_q <= S_HOLD;
              end
            end else begin
              n_q     <= cand_n;
              d_q     <= VALUE_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
              start_q <= 1'b1;
              state_q <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (div_done) begin
            // quotient below divisor: no divisor left, so prime; else a zero remainder means composite
            if (q_lt_d || rem_zero) begin
              if (out_free) begin
                out_valid_q <= 1'b1;
                flag_q      <= q_lt_d;
                state_q     <= S_IDLE;
              end else begin
                pend_q  <= q_lt_d;
                state_q <= S_HOLD;
              end
            end else begin
              d_q     <= d_q + VALUE_WIDTH'(tdpt_pkg::DIVISOR_STEP);
              start_q <= 1'b1;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            flag_q      <= pend_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_prime_flag_o = flag_q;

endmodule

>>> design/tdpt_checker.sv
// tdpt_checker: port-level checks for the trial division prime test core
// depends on tdpt_pkg; bound to trial_division_prime_test_core below

module tdpt_checker #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH
) (
  input logic                                        clk_i,
  input logic                                        rst_ni,
  input logic                                        in_valid_i,
  input logic                                        in_stall_o,
  input logic signed [tdpt_pkg::CANDIDATE_WIDTH-1:0] candidate_i,
  input logic                                        out_valid_o,
  input logic                                        out_stall_i,
  input logic                                        is_prime_flag_o
);

  logic in_acc;
  logic out_room;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_room = !out_valid_o || !out_stall_i;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(is_prime_flag_o))
    else $error("stalled result word dropped or changed");

  // two is reported prime on the next cycle
  a_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && out_room &&
    candidate_i == tdpt_pkg::CANDIDATE_WIDTH'(tdpt_pkg::SMALLEST_PRIME)
    |=> out_valid_o && is_prime_flag_o)
    else $error("two not reported prime");

  // even values whose bits 7:1 are not one (so not two) are reported composite on the next cycle
  a_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && out_room && !candidate_i[0] && (candidate_i[7:1] != 7'd1)
    |=> out_valid_o && !is_prime_flag_o)
    else $error("even value not reported composite");

  // an odd trial never finishes in the cycle after acceptance
  a_odd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && candidate_i[0] && !candidate_i[VALUE_WIDTH > 32 ? 31 : VALUE_WIDTH-1] &&
    (candidate_i[7:1] != 7'd0) |=> in_stall_o)
    else $error("odd candidate not held for trial division");

endmodule

bind trial_division_prime_test_core tdpt_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_tdpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .candidate_i     (candidate_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .is_prime_flag_o (is_prime_flag_o)
);
